// File: rtl/mfps_pkg.sv
// Shared types and op codes for the monochrome frame store with vertical scroll.
package mfps_pkg;

   typedef enum logic [2:0] {
      OP_SET       = 3'd0,
      OP_CLEAR     = 3'd1,
      OP_CLEAR_ALL = 3'd2,
      OP_SCROLL    = 3'd3,
      OP_READ      = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_PIXEL,
      ST_READ,
      ST_SCROLL,
      ST_SCROLL_END,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [7:0]        x_pos;
      logic [7:0]        y_pos;
      logic signed [7:0] scroll_amount;
      logic [9:0]        read_index;
   } cmd_type;

   typedef struct packed {
      logic       ready;
      logic       result_valid;
      logic [7:0] result_data;
   } status_type;

endpackage

// File: rtl/mfps_frame_ram.sv
// Frame store: one write port, one read port, registered read data.
module mfps_frame_ram #(
   parameter int DEPTH  = 504,
   parameter int ADDR_W = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mfps_ctrl.sv
// Operation sequencer: pixel read-modify-write, clear sweep, scroll walk and byte read.
module mfps_ctrl #(
   parameter int  PANEL_WIDTH  = 84,
   parameter int  PANEL_HEIGHT = 48,
   localparam int ADDR_W       = $clog2(PANEL_WIDTH * (PANEL_HEIGHT / 8))
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  mfps_pkg::cmd_type      cmd,
   input  logic                   rotate,
   input  logic                   result_taken,
   output mfps_pkg::status_type   status,
   output logic                   ram_we,
   output logic [ADDR_W-1:0]      ram_waddr,
   output logic [7:0]             ram_wdata,
   output logic                   ram_re,
   output logic [ADDR_W-1:0]      ram_raddr,
   input  logic [7:0]             ram_rdata
);

   localparam int PAGES  = PANEL_HEIGHT / 8;
   localparam int ROWS   = PAGES * 8;
   localparam int STORE  = PANEL_WIDTH * PAGES;
   localparam int COL_W  = $clog2(PANEL_WIDTH);
   localparam int PG_W   = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int K_W    = $clog2(PAGES + 1);
   localparam int SPG_W  = PG_W + 6;

   function automatic logic [7:0] reverse_bits(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   mfps_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                set_ff, set_in;
   logic [2:0]          bit_ff, bit_in;
   logic                rev_ff, rev_in;
   logic                up_ff, up_in;
   logic signed [4:0]   dq_ff, dq_in;
   logic [2:0]          sh_ff, sh_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [K_W-1:0]      k_ff, k_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_inr_ff, s1_inr_in;
   logic [K_W-1:0]      s1_k_ff, s1_k_in;
   logic [COL_W-1:0]    s1_col_ff, s1_col_in;
   logic [7:0]          prev_ff, prev_in;
   logic [7:0]          hold_ff, hold_in;

   logic                    fin;
   logic [7:0]              fin_data;
   logic [7:0]              cur;
   logic [15:0]             pair;
   logic [15:0]             shifted;
   logic [PG_W-1:0]         wr_page;
   logic signed [SPG_W-1:0] rd_page;
   logic                    rd_inr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mfps_pkg::ST_INIT;
         addr_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff    <= set_in;
      bit_ff    <= bit_in;
      rev_ff    <= rev_in;
      up_ff     <= up_in;
      dq_ff     <= dq_in;
      sh_ff     <= sh_in;
      col_ff    <= col_in;
      k_ff      <= k_in;
      s1_inr_ff <= s1_inr_in;
      s1_k_ff   <= s1_k_in;
      s1_col_ff <= s1_col_in;
      prev_ff   <= prev_in;
      hold_ff   <= hold_in;
   end

   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      set_in      = set_ff;
      bit_in      = bit_ff;
      rev_in      = rev_ff;
      up_in       = up_ff;
      dq_in       = dq_ff;
      sh_in       = sh_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      s1_valid_in = 1'b0;
      s1_inr_in   = s1_inr_ff;
      s1_k_in     = s1_k_ff;
      s1_col_in   = s1_col_ff;
      prev_in     = prev_ff;
      hold_in     = hold_ff;

      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = 8'd0;
      ram_re    = 1'b0;
      ram_raddr = '0;

      status.ready        = 1'b0;
      status.result_valid = 1'b0;
      status.result_data  = 8'd0;
      fin                 = 1'b0;
      fin_data            = 8'd0;

      // scroll write-back: data of the page read last cycle, combined with the one before
      cur     = s1_inr_ff ? ram_rdata : 8'd0;
      pair    = up_ff ? {cur, prev_ff} : {prev_ff, cur};
      shifted = pair >> sh_ff;
      wr_page = up_ff ? PG_W'(32'(s1_k_ff) - 1) : PG_W'(PAGES - 32'(s1_k_ff));
      if (s1_valid_ff) begin
         prev_in = cur;
         if (s1_k_ff != '0) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(32'(s1_col_ff) + PANEL_WIDTH * 32'(wr_page));
            ram_wdata = shifted[7:0];
         end
      end

      // up walks pages ascending, down descending, so every source page of a column
      // is read before that column's write reaches it
      rd_page = up_ff ? (SPG_W'(dq_ff) + SPG_W'(k_ff))
                      : (SPG_W'(PAGES) + SPG_W'(dq_ff) - SPG_W'(k_ff));
      rd_inr  = !rd_page[SPG_W-1] && (rd_page < $signed(SPG_W'(PAGES)));

      case (state_ff)
         mfps_pkg::ST_INIT, mfps_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = 8'd0;
            if (addr_ff == ADDR_W'(STORE - 1)) begin
               addr_in = '0;
               if (state_ff == mfps_pkg::ST_INIT) begin
                  state_in = mfps_pkg::ST_IDLE;
               end else begin
                  fin = 1'b1;
               end
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         mfps_pkg::ST_IDLE: begin
            status.ready = 1'b1;
            if (start) begin
               hold_in  = 8'd0;
               state_in = mfps_pkg::ST_DONE;
               case (cmd.op)
                  mfps_pkg::OP_SET, mfps_pkg::OP_CLEAR: begin
                     if (32'(cmd.x_pos) < PANEL_WIDTH && 32'(cmd.y_pos) < ROWS) begin
                        addr_in   = ADDR_W'(32'(cmd.x_pos) + PANEL_WIDTH * 32'(cmd.y_pos[7:3]));
                        ram_re    = 1'b1;
                        ram_raddr = addr_in;
                        set_in    = (cmd.op == mfps_pkg::OP_SET);
                        bit_in    = cmd.y_pos[2:0];
                        state_in  = mfps_pkg::ST_PIXEL;
                     end
                  end
                  mfps_pkg::OP_CLEAR_ALL: begin
                     addr_in  = '0;
                     state_in = mfps_pkg::ST_CLEAR;
                  end
                  mfps_pkg::OP_SCROLL: begin
                     if (cmd.scroll_amount != 8'sd0) begin
                        up_in    = !cmd.scroll_amount[7];
                        dq_in    = $signed(cmd.scroll_amount[7:3]);
                        sh_in    = cmd.scroll_amount[2:0];
                        col_in   = '0;
                        k_in     = '0;
                        state_in = mfps_pkg::ST_SCROLL;
                     end
                  end
                  mfps_pkg::OP_READ: begin
                     if (32'(cmd.read_index) < STORE) begin
                        ram_re    = 1'b1;
                        ram_raddr = rotate ? ADDR_W'(STORE - 1 - 32'(cmd.read_index))
                                           : ADDR_W'(cmd.read_index);
                        rev_in    = rotate;
                        state_in  = mfps_pkg::ST_READ;
                     end
                  end
                  default: begin
                     state_in = mfps_pkg::ST_DONE;
                  end
               endcase
            end
         end
         mfps_pkg::ST_PIXEL: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = set_ff ? (ram_rdata | (8'd1 << bit_ff))
                               : (ram_rdata & ~(8'd1 << bit_ff));
            fin       = 1'b1;
         end
         mfps_pkg::ST_READ: begin
            fin      = 1'b1;
            fin_data = rev_ff ? reverse_bits(ram_rdata) : ram_rdata;
         end
         mfps_pkg::ST_SCROLL: begin
            s1_valid_in = 1'b1;
            s1_inr_in   = rd_inr;
            s1_k_in     = k_ff;
            s1_col_in   = col_ff;
            if (rd_inr) begin
               ram_re    = 1'b1;
               ram_raddr = ADDR_W'(32'(col_ff) + PANEL_WIDTH * 32'(rd_page[PG_W-1:0]));
            end
            if (k_ff == K_W'(PAGES)) begin
               k_in = '0;
               if (col_ff == COL_W'(PANEL_WIDTH - 1)) begin
                  state_in = mfps_pkg::ST_SCROLL_END;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         mfps_pkg::ST_SCROLL_END: begin
            fin = 1'b1;
         end
         mfps_pkg::ST_DONE: begin
            status.result_valid = 1'b1;
            status.result_data  = hold_ff;
            if (result_taken) begin
               state_in = mfps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mfps_pkg::ST_IDLE;
         end
      endcase

      // result goes straight out when the output register can take it, else it is held
      if (fin) begin
         status.result_valid = 1'b1;
         status.result_data  = fin_data;
         hold_in             = fin_data;
         state_in            = result_taken ? mfps_pkg::ST_IDLE : mfps_pkg::ST_DONE;
      end
   end

endmodule

// File: rtl/mono_framebuffer_pixel_scroll_engine_top.sv
// Top level of the monochrome frame store with vertical scroll and panel readout.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   op, x_pos, y_pos, scroll_amount, read_index
//   rsp      out        rsp_valid / rsp_stall   read_data
//   csr      in         csr_write_enable        csr_write_data (rotate_readout)
//
// Set, clear and read byte each do one RAM read, then one write or output.
// Ops that do nothing still return a zero result. Clear all writes one entry a cycle;
// scroll walks every column, the single RAM read port fetching one page a cycle per column.
// After reset a clearing pass over all STORE entries (504 by default) runs with req_stall high.
// A result waits in the output register under rsp_stall while the next request runs.
module mono_framebuffer_pixel_scroll_engine_top #(
   parameter int PANEL_WIDTH  = 84,
   parameter int PANEL_HEIGHT = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_op,
   input  logic [7:0]        req_x_pos,
   input  logic [7:0]        req_y_pos,
   input  logic signed [7:0] req_scroll_amount,
   input  logic [9:0]        req_read_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_read_data,
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   localparam int PAGES  = PANEL_HEIGHT / 8;
   localparam int STORE  = PANEL_WIDTH * PAGES;
   localparam int ADDR_W = $clog2(STORE);

   mfps_pkg::cmd_type    cmd;
   mfps_pkg::status_type status;

   logic              rotate_ff, rotate_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              start;
   logic              result_taken;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   assign cmd.op            = req_op;
   assign cmd.x_pos         = req_x_pos;
   assign cmd.y_pos         = req_y_pos;
   assign cmd.scroll_amount = req_scroll_amount;
   assign cmd.read_index    = req_read_index;

   assign req_stall    = !status.ready;
   assign start        = req_valid && status.ready;
   assign result_taken = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rotate_in    = csr_write_enable ? csr_write_data : rotate_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (status.result_valid && result_taken) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = status.result_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotate_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rotate_ff    <= rotate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   mfps_ctrl #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .cmd          (cmd),
      .rotate       (rotate_ff),
      .result_taken (result_taken),
      .status       (status),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata)
   );

   mfps_frame_ram #(
      .DEPTH  (STORE),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

// File: rtl/mfps_checker.sv
// Port-level checks for the frame store top level, bound to it.
module mfps_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_read_data
);

   // clearing pass holds off requests right after reset
   a_init_stall: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken during clearing pass");

   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // no request is accepted back to back: the sequencer is busy after each accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("back-to-back request accepted");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_data)))
      else $error("stalled response changed");

endmodule

bind mono_framebuffer_pixel_scroll_engine_top mfps_checker u_mfps_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_read_data (rsp_read_data)
);
